@@ hdl/wes_pkg.sv @@
// Shared types and constants for the wave equation stencil step.
// Used by every module of the block except wes_ram; depends on nothing.
`default_nettype none

package wes_pkg;

    localparam int VAL_W     = 24;            // Q4.20 field values
    localparam int COEF_W    = 16;            // Q0.16 coefficient
    localparam int ROW_W     = 16;            // row counter / grid height
    localparam int GW_W      = 13;            // grid width register
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int LAP_W     = VAL_W + 4;     // N+S+E+W-4C, inclusive of +2^26
    localparam int BASE_W    = VAL_W + 2;     // 2C - P
    localparam int PROD_W    = LAP_W + COEF_W + 1;
    localparam int FRAC_SH   = 16;
    localparam int TERM_W    = PROD_W - FRAC_SH;
    localparam int SUM_W     = TERM_W + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QSUM_W      = QCNT_W + 1;

    localparam logic [COEF_W-1:0]        COEF_RST   = 16'd655;
    localparam logic [GW_W-1:0]          WIDTH_RST  = 13'd1024;
    localparam logic [ROW_W-1:0]         HEIGHT_RST = 16'd1024;
    localparam int                       MIN_DIM    = 3;

    localparam logic signed [VAL_W-1:0]  VAL_MAX    = 24'sh7FFFFF;
    localparam logic signed [VAL_W-1:0]  VAL_MIN    = -24'sh800000;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF        = 2'd0,
        CFG_GRID_WIDTH  = 2'd1,
        CFG_GRID_HEIGHT = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic interior;    // full stencil, else main result is zero
        logic border;      // last input row: bottom border point follows
        logic border_fe;   // that border point closes the frame
    } t_wes_flags;

    typedef struct packed {
        logic signed [LAP_W-1:0]  lap;
        logic signed [BASE_W-1:0] base;
        t_wes_flags               flags;
    } t_wes_item;

endpackage

`default_nettype wire

@@ hdl/wes_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wes_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/wes_front.sv @@
// Front end: raster counters, line buffers and Laplacian, pushes words to the queue.
// Depends on wes_pkg and wes_ram.
`default_nettype none

module wes_front #(
    parameter int ADDR_W = 12
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_restart,
    input  wire logic [ADDR_W-1:0]                i_last_col,
    input  wire logic [wes_pkg::ROW_W-1:0]        i_last_row,
    input  wire logic                             i_in_valid,
    output      logic                             o_in_ready,
    input  wire logic signed [wes_pkg::VAL_W-1:0] i_previous_value,
    input  wire logic signed [wes_pkg::VAL_W-1:0] i_current_value,
    input  wire logic [wes_pkg::QCNT_W-1:0]       i_q_count,
    output      logic                             o_push,
    output      wes_pkg::t_wes_item               o_item
);

    localparam int VW = wes_pkg::VAL_W;
    localparam int LW = wes_pkg::LAP_W;
    localparam int BW = wes_pkg::BASE_W;

    logic                       acc;
    logic [ADDR_W-1:0]          r_col, n_col;
    logic [wes_pkg::ROW_W-1:0]  r_row, n_row;

    logic                       r_s1_vld;
    logic                       r_s1_emit;
    wes_pkg::t_wes_flags        r_s1_flags;
    logic [ADDR_W-1:0]          r_s1_col;
    logic [VW-1:0]              r_s1_cur;
    logic [VW-1:0]              r_s1_prev;
    logic [VW-1:0]              r_west;

    logic [VW-1:0]              up_rd, mid_rd, east_rd, mprev_rd;
    logic [ADDR_W-1:0]          east_addr;
    logic signed [LW-1:0]       lap;
    logic signed [BW-1:0]       base;

    // credit: queue words plus the one in flight must leave room
    assign o_in_ready = (wes_pkg::QSUM_W'(i_q_count) + wes_pkg::QSUM_W'(r_s1_vld))
                        < wes_pkg::QSUM_W'(wes_pkg::QUEUE_DEPTH);
    assign acc        = i_in_valid && o_in_ready;
    assign east_addr  = r_col + ADDR_W'(1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (acc) begin
            if (r_col == i_last_col) begin
                n_col = '0;
                n_row = (r_row == i_last_row) ? '0 : r_row + wes_pkg::ROW_W'(1);
            end else begin
                n_col = r_col + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_s1_vld <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_emit            <= (r_row != '0);
            r_s1_flags.interior  <= (r_row > wes_pkg::ROW_W'(1)) && (r_col != '0)
                                    && (r_col != i_last_col);
            r_s1_flags.border    <= (r_row == i_last_row);
            r_s1_flags.border_fe <= (r_col == i_last_col);
            r_s1_col             <= r_col;
            r_s1_cur             <= i_current_value;
            r_s1_prev            <= i_previous_value;
        end
        if (r_s1_vld) begin
            r_west <= mid_rd;
        end
    end

    // line buffers: middle row is kept twice so it can be read at two columns
    wes_ram #(.WIDTH(VW), .DEPTH(2 ** ADDR_W)) u_up_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_vld),
        .i_wr_addr (r_s1_col),
        .i_wr_data (mid_rd),
        .i_rd_en   (acc),
        .i_rd_addr (r_col),
        .o_rd_data (up_rd)
    );

    wes_ram #(.WIDTH(VW), .DEPTH(2 ** ADDR_W)) u_mid_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_vld),
        .i_wr_addr (r_s1_col),
        .i_wr_data (r_s1_cur),
        .i_rd_en   (acc),
        .i_rd_addr (r_col),
        .o_rd_data (mid_rd)
    );

    wes_ram #(.WIDTH(VW), .DEPTH(2 ** ADDR_W)) u_east_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_vld),
        .i_wr_addr (r_s1_col),
        .i_wr_data (r_s1_cur),
        .i_rd_en   (acc),
        .i_rd_addr (east_addr),
        .o_rd_data (east_rd)
    );

    wes_ram #(.WIDTH(VW), .DEPTH(2 ** ADDR_W)) u_mprev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_vld),
        .i_wr_addr (r_s1_col),
        .i_wr_data (r_s1_prev),
        .i_rd_en   (acc),
        .i_rd_addr (r_col),
        .o_rd_data (mprev_rd)
    );

    // stencil centers on the row above the input point
    always_comb begin
        lap  = LW'($signed(up_rd)) + LW'($signed(r_s1_cur)) + LW'($signed(east_rd))
             + LW'($signed(r_west)) - (LW'($signed(mid_rd)) <<< 2);
        base = (BW'($signed(mid_rd)) <<< 1) - BW'($signed(mprev_rd));
    end

    assign o_push       = r_s1_vld && r_s1_emit;
    assign o_item.lap   = lap;
    assign o_item.base  = base;
    assign o_item.flags = r_s1_flags;

    a_s1_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_s1_vld)
        else $error("accepted word did not reach the buffer stage");

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wes_pkg::QSUM_W'(i_q_count) + wes_pkg::QSUM_W'(r_s1_vld))
            <= wes_pkg::QSUM_W'(wes_pkg::QUEUE_DEPTH))
        else $error("queue credit overrun");

endmodule

`default_nettype wire

@@ hdl/wes_queue.sv @@
// Short queue of stencil words between front and back end.
// Depends on wes_pkg.
`default_nettype none

module wes_queue (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire wes_pkg::t_wes_item         i_item,
    input  wire logic                       i_pop,
    output      logic                       o_vld,
    output      wes_pkg::t_wes_item         o_item,
    output      logic [wes_pkg::QCNT_W-1:0] o_count
);

    wes_pkg::t_wes_item             r_mem [wes_pkg::QUEUE_DEPTH];
    logic [wes_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [wes_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [wes_pkg::QCNT_W-1:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + wes_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + wes_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + wes_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - wes_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_vld   = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < wes_pkg::QCNT_W'(wes_pkg::QUEUE_DEPTH)))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ hdl/wes_back.sv @@
// Back end: coefficient multiply, rounding, saturation and result expansion.
// Depends on wes_pkg.
`default_nettype none

module wes_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [wes_pkg::COEF_W-1:0]        i_coef,
    input  wire logic                              i_q_vld,
    input  wire wes_pkg::t_wes_item                i_q_item,
    output      logic                              o_q_pop,
    output      logic                              o_out_valid,
    input  wire logic                              i_out_ready,
    output      logic signed [wes_pkg::VAL_W-1:0]  o_next_value,
    output      logic                              o_frame_end,
    output      logic                              o_run_end
);

    localparam int PW = wes_pkg::PROD_W;
    localparam int SW = wes_pkg::SUM_W;
    localparam int VW = wes_pkg::VAL_W;

    // multiply stage
    logic                       r_m_vld;
    logic signed [PW-1:0]       r_m_prod;
    logic signed [wes_pkg::BASE_W-1:0] r_m_base;
    wes_pkg::t_wes_flags        r_m_flags;
    logic                       m_ready;

    // round / saturate stage
    logic                       r_r_vld;
    logic signed [VW-1:0]       r_r_value;
    wes_pkg::t_wes_flags        r_r_flags;
    logic                       r_ready;

    // output stage, with the bottom border word held behind it
    logic                       r_out_vld;
    logic signed [VW-1:0]       r_out_value;
    logic                       r_out_fe;
    logic                       r_out_re;
    logic                       r_pend;
    logic                       r_pend_fe;
    logic                       out_load;

    logic signed [PW-1:0]       n_prod;
    logic signed [PW-1:0]       rnd;
    logic signed [SW-1:0]       total;
    logic signed [VW-1:0]       n_value;

    assign out_load = (!r_out_vld || i_out_ready) && !r_pend;
    assign r_ready  = !r_r_vld || out_load;
    assign m_ready  = !r_m_vld || r_ready;
    assign o_q_pop  = i_q_vld && m_ready;

    assign n_prod = PW'(i_q_item.lap) * PW'($signed({1'b0, i_coef}));

    always_comb begin
        rnd   = r_m_prod + wes_pkg::ROUND_HALF;
        total = SW'(r_m_base) + SW'($signed(rnd[PW-1:wes_pkg::FRAC_SH]));
        if (!r_m_flags.interior) begin
            n_value = '0;
        end else if (total > SW'(wes_pkg::VAL_MAX)) begin
            n_value = wes_pkg::VAL_MAX;
        end else if (total < SW'(wes_pkg::VAL_MIN)) begin
            n_value = wes_pkg::VAL_MIN;
        end else begin
            n_value = total[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld   <= 1'b0;
            r_r_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            if (m_ready) begin
                r_m_vld <= i_q_vld;
            end
            if (r_ready) begin
                r_r_vld <= r_m_vld;
            end
            if (r_out_vld && i_out_ready && r_pend) begin
                r_out_vld <= 1'b1;
                r_pend    <= 1'b0;
            end else if (out_load && r_r_vld) begin
                r_out_vld <= 1'b1;
                r_pend    <= r_r_flags.border;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_m_prod  <= n_prod;
            r_m_base  <= i_q_item.base;
            r_m_flags <= i_q_item.flags;
        end
        if (r_ready && r_m_vld) begin
            r_r_value <= n_value;
            r_r_flags <= r_m_flags;
        end
        if (r_out_vld && i_out_ready && r_pend) begin
            r_out_value <= '0;
            r_out_fe    <= r_pend_fe;
            r_out_re    <= 1'b1;
        end else if (out_load && r_r_vld) begin
            r_out_value <= r_r_value;
            r_out_fe    <= 1'b0;
            r_out_re    <= !r_r_flags.border;
            r_pend_fe   <= r_r_flags.border_fe;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_next_value = r_out_value;
    assign o_frame_end  = r_out_fe;
    assign o_run_end    = r_out_re;

    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_out_vld)
        else $error("border word pending with empty output stage");

    a_run_end_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_re) |-> r_pend)
        else $error("open run without a following border word");

endmodule

`default_nettype wire

@@ hdl/wave_equation_stencil_step.sv @@
// A result follows the input word one row below it through the buffer stage, the queue and the
// multiply, round and output registers. Throughput: one word per cycle while the queue has credit
// and the output is not stalled; last-row words give two results each, so the output side throttles that row.
// Reset: synchronous active-low; counters, queue and valid bits clear, config
// registers return to defaults; line buffers are not cleared (stale data never reaches a result).
`default_nettype none

module wave_equation_stencil_step #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [wes_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [wes_pkg::CFG_DATA_W-1:0]        i_cfg_wr_data,
    input  wire logic                                  i_in_valid,
    output      logic                                  o_in_ready,
    input  wire logic signed [wes_pkg::VAL_W-1:0]      i_previous_value,
    input  wire logic signed [wes_pkg::VAL_W-1:0]      i_current_value,
    output      logic                                  o_out_valid,
    input  wire logic                                  i_out_ready,
    output      logic signed [wes_pkg::VAL_W-1:0]      o_next_value,
    output      logic                                  o_frame_end,
    output      logic                                  o_run_end
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int EW = ($clog2(MAX_WIDTH + 1) > wes_pkg::GW_W)
                        ? $clog2(MAX_WIDTH + 1) : wes_pkg::GW_W;
    localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);
    localparam logic [EW-1:0] MIN_W_E = EW'(wes_pkg::MIN_DIM);

    logic [wes_pkg::COEF_W-1:0] r_coef;
    logic [wes_pkg::GW_W-1:0]   r_grid_width;
    logic [wes_pkg::ROW_W-1:0]  r_grid_height;
    logic                       restart;

    logic [EW-1:0]              width_e, eff_width;
    logic [AW-1:0]              last_col;
    logic [wes_pkg::ROW_W-1:0]  last_row;

    logic                       q_push, q_pop, q_vld;
    wes_pkg::t_wes_item         q_in_item, q_out_item;
    logic [wes_pkg::QCNT_W-1:0] q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef        <= wes_pkg::COEF_RST;
            r_grid_width  <= wes_pkg::WIDTH_RST;
            r_grid_height <= wes_pkg::HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                wes_pkg::CFG_COEF: begin
                    r_coef <= i_cfg_wr_data;
                end
                wes_pkg::CFG_GRID_WIDTH: begin
                    r_grid_width <= i_cfg_wr_data[wes_pkg::GW_W-1:0];
                end
                wes_pkg::CFG_GRID_HEIGHT: begin
                    r_grid_height <= i_cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    // any write to a known register restarts the frame
    always_comb begin
        case (i_cfg_index)
            wes_pkg::CFG_COEF,
            wes_pkg::CFG_GRID_WIDTH,
            wes_pkg::CFG_GRID_HEIGHT: restart = i_cfg_wr_en;
            default:                  restart = 1'b0;
        endcase
    end

    always_comb begin
        width_e = EW'(r_grid_width);
        if (width_e < MIN_W_E) begin
            eff_width = MIN_W_E;
        end else if (width_e > MAX_W_E) begin
            eff_width = MAX_W_E;
        end else begin
            eff_width = width_e;
        end
        last_col = AW'(eff_width - EW'(1));
        last_row = (r_grid_height < wes_pkg::ROW_W'(wes_pkg::MIN_DIM))
                   ? wes_pkg::ROW_W'(wes_pkg::MIN_DIM - 1)
                   : r_grid_height - wes_pkg::ROW_W'(1);
    end

    wes_front #(.ADDR_W(AW)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_restart        (restart),
        .i_last_col       (last_col),
        .i_last_row       (last_row),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_previous_value (i_previous_value),
        .i_current_value  (i_current_value),
        .i_q_count        (q_count),
        .o_push           (q_push),
        .o_item           (q_in_item)
    );

    wes_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_item  (q_out_item),
        .o_count (q_count)
    );

    wes_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_coef       (r_coef),
        .i_q_vld      (q_vld),
        .i_q_item     (q_out_item),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_next_value (o_next_value),
        .o_frame_end  (o_frame_end),
        .o_run_end    (o_run_end)
    );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking bench for wave_equation_stencil_step: a directed table, then random
// phases over several grid shapes and coefficients, checked against a leapfrog predictor.
// Depends on wes_pkg and the wave_equation_stencil_step top level.

module tb;

    localparam int VAL_W      = wes_pkg::VAL_W;
    localparam int CFG_IDX_W  = wes_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = wes_pkg::CFG_DATA_W;
    localparam int COEF_W     = wes_pkg::COEF_W;
    localparam int GW_W       = wes_pkg::GW_W;
    localparam int ROW_W      = wes_pkg::ROW_W;
    localparam int MIN_DIM    = wes_pkg::MIN_DIM;
    localparam logic signed [VAL_W-1:0] VAL_MAX = wes_pkg::VAL_MAX;
    localparam logic signed [VAL_W-1:0] VAL_MIN = wes_pkg::VAL_MIN;

    localparam int MAX_W         = 4096;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 1300;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [VAL_W-1:0] next;
        logic                    fe;
        logic                    re;
    } t_next_point;

    typedef struct {
        bit                      is_cfg;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic signed [VAL_W-1:0] prev;
        logic signed [VAL_W-1:0] cur;
        int                      n;
        logic signed [VAL_W-1:0] v0;
        bit                      fe;
    } t_stim_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_wr_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic signed [VAL_W-1:0]       i_previous_value = '0;
    logic signed [VAL_W-1:0]       i_current_value = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic signed [VAL_W-1:0]       o_next_value;
    logic                          o_frame_end;
    logic                          o_run_end;

    wave_equation_stencil_step #(.MAX_WIDTH(MAX_W)) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_previous_value (i_previous_value),
        .i_current_value  (i_current_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_next_value     (o_next_value),
        .o_frame_end      (o_frame_end),
        .o_run_end        (o_run_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state: line stores, raster position, west neighbor, registers
    logic signed [VAL_W-1:0] above_cur [MAX_W];
    logic signed [VAL_W-1:0] mid_cur   [MAX_W];
    logic signed [VAL_W-1:0] mid_prev  [MAX_W];
    logic signed [VAL_W-1:0] west_cur;
    int unsigned             col_pos;
    int unsigned             row_pos;
    logic [COEF_W-1:0]       coef_reg;
    logic [GW_W-1:0]         width_reg;
    logic [ROW_W-1:0]        height_reg;

    t_next_point step_out [2];
    int          step_cnt;
    t_next_point next_points [$];
    t_next_point want;
    t_stim_row   stim_rows [$];

    int idle_pct  = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    function automatic logic signed [VAL_W-1:0] leapfrog(
        input longint n, input longint s, input longint e, input longint w,
        input longint c, input longint p, input longint k);
        longint lap;
        longint term;
        longint r;
        lap  = n + s + e + w - 4 * c;
        term = (lap * k + 32768) >>> 16;    // round half up to Q4.20
        r    = 2 * c - p + term;
        if (r > longint'(VAL_MAX)) r = longint'(VAL_MAX);
        if (r < longint'(VAL_MIN)) r = longint'(VAL_MIN);
        return VAL_W'(r);
    endfunction

    task automatic predict_point(input logic signed [VAL_W-1:0] prev,
                                 input logic signed [VAL_W-1:0] cur);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        logic signed [VAL_W-1:0] old_mid;
        logic signed [VAL_W-1:0] old_mp;
        logic signed [VAL_W-1:0] old_up;
        logic signed [VAL_W-1:0] v;
        w = width_reg;
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > MAX_W) w = MAX_W;
        h = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        old_mid = mid_cur[c];
        old_mp  = mid_prev[c];
        old_up  = above_cur[c];
        step_cnt = 0;
        if (r >= 1) begin
            v = '0;
            if (r != 1 && c != 0 && c != w - 1 && c + 1 < MAX_W)
                v = leapfrog(old_up, cur, mid_cur[c + 1], west_cur, old_mid, old_mp,
                             longint'(coef_reg));
            step_out[0].next = v;
            step_out[0].fe = 1'b0;
            step_out[0].re = 1'b0;
            step_cnt = 1;
        end
        // last row also flushes the bottom border point
        if (r == h - 1) begin
            step_out[step_cnt].next = '0;
            step_out[step_cnt].fe = (c == w - 1);
            step_out[step_cnt].re = 1'b0;
            step_cnt++;
        end
        if (step_cnt > 0) step_out[step_cnt - 1].re = 1'b1;
        above_cur[c] = old_mid;
        mid_cur[c]   = cur;
        mid_prev[c]  = prev;
        west_cur     = old_mid;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (next_points.size() != 0) @(negedge i_clk);
    endtask

    // idle point for register writes: nothing pending, pipeline flushed
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= data;
        @(posedge i_clk);
        case (idx)
            wes_pkg::CFG_COEF:        coef_reg   = data[COEF_W-1:0];
            wes_pkg::CFG_GRID_WIDTH:  width_reg  = data[GW_W-1:0];
            wes_pkg::CFG_GRID_HEIGHT: height_reg = data[ROW_W-1:0];
            default: ;
        endcase
        // known registers restart the frame, stores keep their data
        if (idx == wes_pkg::CFG_COEF || idx == wes_pkg::CFG_GRID_WIDTH
                || idx == wes_pkg::CFG_GRID_HEIGHT) begin
            col_pos = 0;
            row_pos = 0;
        end
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // typed rows carry their own expectation; the predictor still tracks state
    task automatic send_point(input t_stim_row row, input bit typed);
        bit taken;
        int k;
        @(negedge i_clk);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_previous_value <= row.prev;
        i_current_value  <= row.cur;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (o_in_ready) taken = 1'b1;
            else @(negedge i_clk);
        end
        predict_point(row.prev, row.cur);
        if (typed) begin
            step_cnt = row.n;
            for (k = 0; k < row.n; k++) begin
                step_out[k].next = (k == 0) ? row.v0 : '0;
                step_out[k].re   = (k == row.n - 1);
                step_out[k].fe   = (k == row.n - 1) && row.fe;
            end
        end
        for (k = 0; k < step_cnt; k++) next_points.push_back(step_out[k]);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row = '{is_cfg: 1'b1, idx: idx, data: data, prev: '0, cur: '0,
                n: 0, v0: '0, fe: 1'b0};
        stim_rows.push_back(row);
    endtask

    task automatic add_point(input logic signed [VAL_W-1:0] prev,
                             input logic signed [VAL_W-1:0] cur,
                             input int n, input logic signed [VAL_W-1:0] v0, input bit fe);
        t_stim_row row;
        row = '{is_cfg: 1'b0, idx: '0, data: '0, prev: prev, cur: cur,
                n: n, v0: v0, fe: fe};
        stim_rows.push_back(row);
    endtask

    function automatic logic signed [VAL_W-1:0] rand_val();
        case ($urandom_range(9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2, 3, 4: return VAL_W'($urandom);
            default: return VAL_W'(int'($urandom_range(2097152)) - 1048576);
        endcase
    endfunction

    task automatic run_phase(input logic [CFG_DATA_W-1:0] coef,
                             input logic [CFG_DATA_W-1:0] wdata,
                             input logic [CFG_DATA_W-1:0] hdata,
                             input int count, input int mode, input bit pause);
        t_stim_row row;
        int i;
        settle();
        write_reg(wes_pkg::CFG_COEF, coef);
        write_reg(wes_pkg::CFG_GRID_WIDTH, wdata);
        write_reg(wes_pkg::CFG_GRID_HEIGHT, hdata);
        case (mode)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 73; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 73; end
            default: begin idle_pct = 18; stall_pct = 18; end
        endcase
        row = '{is_cfg: 1'b0, idx: '0, data: '0, prev: '0, cur: '0,
                n: 0, v0: '0, fe: 1'b0};
        for (i = 0; i < count; i++) begin
            if (pause && i == count / 2) wait_drained();
            row.prev = rand_val();
            row.cur  = rand_val();
            send_point(row, 1'b0);
        end
    endtask

    always @(negedge i_clk)
        i_out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (next_points.size() == 0) begin
                $error("unexpected word: next_value %0d", o_next_value);
                mismatches++;
            end else begin
                want = next_points.pop_front();
                if (o_next_value !== want.next) begin
                    $error("next_value: expected %0d, got %0d", want.next, o_next_value);
                    mismatches++;
                end
                if (o_frame_end !== want.fe) begin
                    $error("frame_end: expected %0b, got %0b", want.fe, o_frame_end);
                    mismatches++;
                end
                if (o_run_end !== want.re) begin
                    $error("run_end: expected %0b, got %0b", want.re, o_run_end);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        logic signed [VAL_W-1:0] hi;
        logic signed [VAL_W-1:0] lo;
        logic [CFG_DATA_W-1:0]   coef;
        logic [CFG_DATA_W-1:0]   wdata;
        logic [CFG_DATA_W-1:0]   hdata;
        int                      w;
        int                      count;
        int                      total;
        int                      p;

        coef_reg   = wes_pkg::COEF_RST;
        width_reg  = wes_pkg::WIDTH_RST;
        height_reg = wes_pkg::HEIGHT_RST;
        col_pos    = 0;
        row_pos    = 0;
        west_cur   = '0;
        for (int i = 0; i < MAX_W; i++) begin
            above_cur[i] = '0;
            mid_cur[i]   = '0;
            mid_prev[i]  = '0;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // row 0 of the default grid: no results
        add_point('0, '0, 0, '0, 1'b0);
        add_point(VAL_MIN, VAL_MAX, 0, '0, 1'b0);
        add_cfg(CFG_UNUSED, 16'hFFFF);      // ignored, frame keeps going
        add_point(24'sd123, -24'sd456, 0, '0, 1'b0);
        add_cfg(wes_pkg::CFG_GRID_WIDTH, 16'hE002);  // top bits dropped, 2 clamps to 3
        add_cfg(wes_pkg::CFG_GRID_HEIGHT, 16'h0000); // clamps to 3
        add_cfg(wes_pkg::CFG_COEF, 16'hFFFF);
        // two 3x3 frames of flat fields: the one interior point saturates
        for (int f = 0; f < 2; f++) begin
            hi = f ? VAL_MIN : VAL_MAX;
            lo = f ? VAL_MAX : VAL_MIN;
            repeat (3) add_point(lo, hi, 0, '0, 1'b0);
            repeat (3) add_point(lo, hi, 1, '0, 1'b0);
            add_point(lo, hi, 2, '0, 1'b0);
            add_point(lo, hi, 2, hi, 1'b0);
            add_point(lo, hi, 2, '0, 1'b1);
        end

        idle_pct  = 18;
        stall_pct = 18;
        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_cfg) begin
                settle();
                write_reg(stim_rows[i].idx, stim_rows[i].data);
            end else begin
                send_point(stim_rows[i], 1'b1);
            end
        end

        total = 0;
        p = 0;
        while (total < RANDOM_ITEMS) begin
            case (p)
                0: begin coef = 16'h0000; wdata = 16'd3; hdata = 16'd3; end
                1: begin coef = 16'hFFFF; wdata = 16'd3; hdata = 16'hFFFF; end
                default: begin
                    case ($urandom_range(3))
                        0:       coef = 16'h0000;
                        1:       coef = 16'hFFFF;
                        2:       coef = wes_pkg::COEF_RST;
                        default: coef = CFG_DATA_W'($urandom_range(65535));
                    endcase
                    case ($urandom_range(5))
                        0:       w = $urandom_range(2);
                        1:       w = 3;
                        2, 3:    w = $urandom_range(12, 4);
                        default: w = $urandom_range(64, 13);
                    endcase
                    wdata = {3'($urandom_range(7)), 13'(w)};
                    case ($urandom_range(4))
                        0:       hdata = CFG_DATA_W'($urandom_range(2));
                        1:       hdata = 16'd3;
                        2, 3:    hdata = CFG_DATA_W'($urandom_range(10, 4));
                        default: hdata = CFG_DATA_W'($urandom_range(65535, 11));
                    endcase
                end
            endcase
            count = $urandom_range(140, 40);
            run_phase(coef, wdata, hdata, count, p % 4, (p % 3) == 0);
            total += count;
            p++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && next_points.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
